/* design/per_source_packet_threshold_unit_assert.svh */
// Assertion macros used by the per-source packet threshold checker.
`ifndef PER_SOURCE_PACKET_THRESHOLD_UNIT_ASSERT_SVH
`define PER_SOURCE_PACKET_THRESHOLD_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PSPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pspt assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define PSPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pspt assertion failed");

`endif

/* design/pspt_pkg.sv */
// Package of the per-source packet threshold unit: constants, beat and control types.
package pspt_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int COUNT_BITS_DEF    = 20;

    localparam int ADDR_W      = 32;
    localparam int TYPE_W      = 16;
    localparam int THRESH_W    = 20;
    localparam int OUT_COUNT_W = 20;

    localparam logic [TYPE_W-1:0]      IPV4_TYPE    = 16'h0800;
    localparam logic [THRESH_W-1:0]    THRESH_RESET = 20'd1000;
    localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = {OUT_COUNT_W{1'b1}};

    localparam logic KIND_ALARM   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [TYPE_W-1:0] frame_type;
        logic [ADDR_W-1:0] source_address;
        logic              end_of_window;
    } t_in_item;

    typedef struct packed {
        logic                   item_kind;
        logic [ADDR_W-1:0]      alarm_address;
        logic [OUT_COUNT_W-1:0] alarm_count;
        logic                   table_overflowed;
        logic                   last_of_run;
    } t_out_item;

    // Broadcast controls from the sequencer to every table cell.
    typedef struct packed {
        logic count_en;  // IPv4 key on the bus this cycle
        logic alloc_en;  // key missed everywhere and a free cell exists
        logic shift;     // dump: every cell loads its upper neighbor
    } t_cell_ctl;

endpackage

/* design/pspt_cell.sv */
// One table cell: holds a source address and its saturating count.
module pspt_cell #(
    parameter int COUNT_BITS = pspt_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pspt_pkg::t_cell_ctl         i_ctl,
    input  logic [pspt_pkg::ADDR_W-1:0] i_key,
    input  logic                        i_prev_occ,
    input  logic                        i_nxt_occ,
    input  logic [pspt_pkg::ADDR_W-1:0] i_nxt_addr,
    input  logic [COUNT_BITS-1:0]       i_nxt_cnt,
    output logic                        o_occ,
    output logic [pspt_pkg::ADDR_W-1:0] o_addr,
    output logic [COUNT_BITS-1:0]       o_cnt,
    output logic                        o_hit
);

    logic                        r_occ;
    logic [pspt_pkg::ADDR_W-1:0] r_addr;
    logic [COUNT_BITS-1:0]       r_cnt;
    logic                        take;

    assign o_hit = r_occ && (r_addr == i_key);
    // cells fill in order, so the first free cell is the one whose lower neighbor is taken
    assign take  = i_ctl.alloc_en && !r_occ && i_prev_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            priority if (i_ctl.shift) begin
                r_occ <= i_nxt_occ;
            end else if (take) begin
                r_occ <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift) begin
            r_addr <= i_nxt_addr;
            r_cnt  <= i_nxt_cnt;
        end else if (i_ctl.count_en && o_hit && (r_cnt != {COUNT_BITS{1'b1}})) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (take) begin
            r_addr <= i_key;
            r_cnt  <= COUNT_BITS'(1);
        end
    end

    assign o_occ  = r_occ;
    assign o_addr = r_addr;
    assign o_cnt  = r_cnt;

endmodule

/* design/per_source_packet_threshold_unit.sv */
// Top level of the per-source packet threshold unit: sequencer and row of table cells.
//
//  channel | direction | handshake            | beat
//  in      | input     | i_in_valid/o_in_stall | t_in_item (header)
//  out     | output    | o_out_valid/i_out_stall | t_out_item (alarm or summary)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | alarm_threshold
//
// A header is accepted and registered; then every cell compares its address with the key
// and, for an IPv4 header, the matching or first free cell updates.
// At a window end the cell row shifts toward cell 0 and a summary follows; an output stall
// on an alarm or the summary holds the dump.
// Input is stalled during that dump. Reset clears the occupancy flags at once; no sweep.
module per_source_packet_threshold_unit #(
    parameter int TABLE_ENTRIES = pspt_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = pspt_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pspt_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pspt_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pspt_pkg::THRESH_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (COUNT_BITS > pspt_pkg::THRESH_W) ? COUNT_BITS : pspt_pkg::THRESH_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                          r_state;
    logic                          r_pend;
    pspt_pkg::t_in_item            r_item;
    logic [pspt_pkg::THRESH_W-1:0] r_thr;
    logic [CNT_W-1:0]              r_entries;
    logic                          r_ovf;
    logic                          r_out_valid;
    pspt_pkg::t_out_item           r_out;
    pspt_pkg::t_out_item           n_out;

    logic [TABLE_ENTRIES-1:0]        occ;
    logic [TABLE_ENTRIES-1:0]        hit;
    logic [pspt_pkg::ADDR_W-1:0]     addr [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]           cnt  [TABLE_ENTRIES];
    pspt_pkg::t_cell_ctl             ctl;

    logic in_acc, is_ipv4, any_hit, full, out_free, load;
    logic head_alarm;
    logic [CMP_W-1:0] head_ext;

    assign o_in_stall  = r_pend || (r_state == ST_DUMP);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign is_ipv4  = r_item.frame_type == pspt_pkg::IPV4_TYPE;
    assign any_hit  = |hit;
    assign full     = r_entries == CNT_W'(TABLE_ENTRIES);
    assign out_free = !r_out_valid || !i_out_stall;

    assign head_ext   = CMP_W'(cnt[0]);
    assign head_alarm = occ[0] && (head_ext > CMP_W'(r_thr));

    always_comb begin
        ctl.count_en = r_pend && is_ipv4;
        ctl.alloc_en = r_pend && is_ipv4 && !any_hit && !full;
        // head cell moves on unless it holds an alarm that cannot leave yet
        ctl.shift    = (r_state == ST_DUMP) && occ[0] && (!head_alarm || out_free);
    end

    always_comb begin
        n_out.table_overflowed = r_ovf;
        if (occ[0]) begin
            n_out.item_kind     = pspt_pkg::KIND_ALARM;
            n_out.alarm_address = addr[0];
            n_out.alarm_count   = (head_ext > CMP_W'(pspt_pkg::OUT_COUNT_MAX)) ?
                                  pspt_pkg::OUT_COUNT_MAX :
                                  head_ext[pspt_pkg::OUT_COUNT_W-1:0];
            n_out.last_of_run   = 1'b0;
        end else begin
            n_out.item_kind     = pspt_pkg::KIND_SUMMARY;
            n_out.alarm_address = '0;
            n_out.alarm_count   = pspt_pkg::OUT_COUNT_W'(r_entries);
            n_out.last_of_run   = 1'b1;
        end
        load = (r_state == ST_DUMP) && out_free && (head_alarm || !occ[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_thr       <= pspt_pkg::THRESH_RESET;
            r_entries   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_pend <= 1'b1;
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                        if (ctl.alloc_en) begin
                            r_entries <= r_entries + 1'b1;
                        end
                        if (is_ipv4 && !any_hit && full) begin
                            r_ovf <= 1'b1;
                        end
                        if (r_item.end_of_window) begin
                            r_state <= ST_DUMP;
                        end
                    end
                end
                ST_DUMP: begin
                    if (load && !occ[0]) begin
                        r_entries <= '0;
                        r_ovf     <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic                        prev_occ;
        logic                        nxt_occ;
        logic [pspt_pkg::ADDR_W-1:0] nxt_addr;
        logic [COUNT_BITS-1:0]       nxt_cnt;

        if (g == 0) begin : g_first
            assign prev_occ = 1'b1;
        end else begin : g_mid
            assign prev_occ = occ[g-1];
        end

        if (g == TABLE_ENTRIES - 1) begin : g_last
            assign nxt_occ  = 1'b0;
            assign nxt_addr = '0;
            assign nxt_cnt  = '0;
        end else begin : g_inner
            assign nxt_occ  = occ[g+1];
            assign nxt_addr = addr[g+1];
            assign nxt_cnt  = cnt[g+1];
        end

        pspt_cell #(
            .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_key      (r_item.source_address),
            .i_prev_occ (prev_occ),
            .i_nxt_occ  (nxt_occ),
            .i_nxt_addr (nxt_addr),
            .i_nxt_cnt  (nxt_cnt),
            .o_occ      (occ[g]),
            .o_addr     (addr[g]),
            .o_cnt      (cnt[g]),
            .o_hit      (hit[g])
        );
    end

endmodule

/* design/pspt_checker.sv */
// Port-level checker for the per-source packet threshold unit, bound to the top level.
`include "per_source_packet_threshold_unit_assert.svh"

module pspt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pspt_pkg::t_out_item o_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    `PSPT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    // input is stalled in the cycle after a header is accepted, while the header is worked
    `PSPT_ASSERT_NEXT(a_acc_stall, in_acc, o_in_stall)
    `PSPT_ASSERT_NOW(a_summary_shape,
        o_out_valid && (o_out_data.item_kind == pspt_pkg::KIND_SUMMARY),
        o_out_data.last_of_run && (o_out_data.alarm_address == '0))
    `PSPT_ASSERT_NOW(a_alarm_not_last,
        o_out_valid && (o_out_data.item_kind == pspt_pkg::KIND_ALARM),
        !o_out_data.last_of_run && (o_out_data.alarm_count != '0))

endmodule

bind per_source_packet_threshold_unit pspt_checker u_pspt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
